[design/mvp_pkg.sv]
// Shared constants, types and codes for the matrix-vector product block.
package mvp_pkg;

  localparam int MAX_LENGTH_DEFAULT    = 64;
  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam int ROW_BITS    = 6;
  localparam int VALUE_BITS  = 32;
  localparam int SIZE_BITS   = 7;
  localparam int ACC_BITS    = 64;
  localparam int QUEUE_DEPTH = 4;

  // Item operation codes
  localparam logic OP_VECTOR = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  // Configuration register indexes
  localparam logic REG_VECTOR_LENGTH = 1'b0;
  localparam logic REG_COLUMN_COUNT  = 1'b1;

  // One multiply-accumulate job handed from front to back
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic signed [VALUE_BITS-1:0] coeff;
    logic                         last;
  } mac_item_t;

endpackage

[design/mvp_if.sv]
// Stream interfaces for input items and result items.
interface mvp_item_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic [mvp_pkg::ROW_BITS-1:0]          row_index;
  logic signed [mvp_pkg::VALUE_BITS-1:0] value;

  modport source (output valid, output op, output row_index, output value, input ready);
  modport sink   (input valid, input op, input row_index, input value, output ready);
endinterface

interface mvp_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [mvp_pkg::ROW_BITS-1:0]          column_number;
  logic signed [mvp_pkg::VALUE_BITS-1:0] product_sum;
  logic                                  final_result;

  modport source (output valid, output column_number, output product_sum,
                  output final_result, input ready);
  modport sink   (input valid, input column_number, input product_sum,
                  input final_result, output ready);
endinterface

[design/mvp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mvp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mvp_queue.sv]
// Short FIFO of multiply-accumulate jobs between front and back.
module mvp_queue (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  input  mvp_pkg::mac_item_t                       push_data,
  input  logic                                     pop,
  output logic                                     head_valid,
  output mvp_pkg::mac_item_t                       head,
  output logic [$clog2(mvp_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(mvp_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mvp_pkg::QUEUE_DEPTH + 1);

  mvp_pkg::mac_item_t slots [mvp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;

  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop && head_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (count == CW'(mvp_pkg::QUEUE_DEPTH)) |-> !push || (pop && head_valid))
    else $error("job queue overrun");

endmodule

[design/mvp_front.sv]
// Front end: accept items, write vector elements, fetch coefficients, queue jobs.
module mvp_front #(
  parameter int MAX_LENGTH = mvp_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  mvp_item_if.sink                                  item,
  input  logic [mvp_pkg::SIZE_BITS-1:0]             eff_len,
  input  logic [$clog2(mvp_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic                                      push,
  output mvp_pkg::mac_item_t                        push_data
);

  localparam int DEPTH = (MAX_LENGTH < 64) ? MAX_LENGTH : 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(mvp_pkg::QUEUE_DEPTH + 1);

  logic                                  accept;
  logic                                  vec_write;
  logic                                  mat_take;
  logic                                  mat_last;
  logic [AW-1:0]                         addr;
  logic                                  s1_valid;
  logic                                  s1_last;
  logic signed [mvp_pkg::VALUE_BITS-1:0] s1_value;
  logic [mvp_pkg::VALUE_BITS-1:0]        coeff;

  // Reserve room for the job already in flight toward the queue
  assign item.ready = ((CW+1)'(q_count) + (CW+1)'(s1_valid)) < (CW+1)'(mvp_pkg::QUEUE_DEPTH);
  assign accept     = item.valid && item.ready;
  assign addr       = item.row_index[AW-1:0];

  always_comb begin
    vec_write = 1'b0;
    mat_take  = 1'b0;
    mat_last  = 1'b0;
    case (item.op)
      mvp_pkg::OP_VECTOR: begin
        vec_write = accept &&
          ({1'b0, item.row_index} < mvp_pkg::SIZE_BITS'(DEPTH));
      end
      mvp_pkg::OP_MATRIX: begin
        mat_take = accept && ({1'b0, item.row_index} < eff_len);
        mat_last = ({1'b0, item.row_index} == eff_len - mvp_pkg::SIZE_BITS'(1));
      end
      default: begin
        vec_write = 1'b0;
      end
    endcase
  end

  mvp_ram #(
    .WIDTH (mvp_pkg::VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_vector_store (
    .clk   (clk),
    .we    (vec_write),
    .waddr (addr),
    .wdata (item.value),
    .raddr (addr),
    .rdata (coeff)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= mat_take;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_take) begin
      s1_value <= item.value;
      s1_last  <= mat_last;
    end
  end

  assign push            = s1_valid;
  assign push_data.value = s1_value;
  assign push_data.coeff = coeff;
  assign push_data.last  = s1_last;

  assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count < CW'(mvp_pkg::QUEUE_DEPTH)))
    else $error("job pushed into a full queue");

endmodule

[design/mvp_back.sv]
// Back end: multiply, round, saturating accumulate and result register.
module mvp_back #(
  parameter int FRACTION_BITS = mvp_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_clear,
  input  logic [mvp_pkg::SIZE_BITS-1:0] eff_cols,
  input  logic                          head_valid,
  input  mvp_pkg::mac_item_t            head,
  output logic                          pop,
  mvp_result_if.source                  result
);

  localparam int AB = mvp_pkg::ACC_BITS;
  localparam logic signed [AB-1:0] HALF    = (AB'(1) << FRACTION_BITS) >> 1;
  localparam logic signed [AB-1:0] ACC_MAX = {1'b0, {(AB-1){1'b1}}};
  localparam logic signed [AB-1:0] ACC_MIN = {1'b1, {(AB-1){1'b0}}};
  localparam logic signed [mvp_pkg::VALUE_BITS-1:0] SUM_MAX =
    {1'b0, {(mvp_pkg::VALUE_BITS-1){1'b1}}};
  localparam logic signed [mvp_pkg::VALUE_BITS-1:0] SUM_MIN =
    {1'b1, {(mvp_pkg::VALUE_BITS-1){1'b0}}};

  logic                              en;
  logic signed [AB-1:0]              mul;
  logic                              p_valid;
  logic                              p_last;
  logic signed [AB-1:0]              p_product;
  logic signed [AB-1:0]              rounded;
  logic                              r_valid;
  logic                              r_last;
  logic signed [AB-1:0]              r_scaled;
  logic signed [AB-1:0]              acc;
  logic signed [AB-1:0]              acc_sum;
  logic signed [AB-1:0]              acc_sat;
  logic signed [mvp_pkg::VALUE_BITS-1:0] sum32;
  logic [mvp_pkg::ROW_BITS-1:0]      col;
  logic                              col_last;
  logic                              closing;

  // Stall only when a column result meets a full, unread output register
  assign en      = !(r_valid && r_last && result.valid && !result.ready);
  assign pop     = en && head_valid;
  assign closing = en && r_valid && r_last;

  assign mul     = head.value * head.coeff;
  assign rounded = (p_product + HALF) >>> FRACTION_BITS;

  always_comb begin
    acc_sum = acc + r_scaled;
    if ((acc[AB-1] == r_scaled[AB-1]) && (acc_sum[AB-1] != acc[AB-1])) begin
      acc_sat = acc[AB-1] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum;
    end
    if ((&acc_sat[AB-1:mvp_pkg::VALUE_BITS-1]) || !(|acc_sat[AB-1:mvp_pkg::VALUE_BITS-1])) begin
      sum32 = acc_sat[mvp_pkg::VALUE_BITS-1:0];
    end else begin
      sum32 = acc_sat[AB-1] ? SUM_MIN : SUM_MAX;
    end
    col_last = ({1'b0, col} >= eff_cols - mvp_pkg::SIZE_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      r_valid      <= 1'b0;
      acc          <= '0;
      col          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (en) begin
        p_valid <= head_valid;
        r_valid <= p_valid;
      end
      if (cfg_clear) begin
        acc <= '0;
        col <= '0;
      end else if (en && r_valid) begin
        if (r_last) begin
          acc <= '0;
          col <= col_last ? '0 : col + mvp_pkg::ROW_BITS'(1);
        end else begin
          acc <= acc_sat;
        end
      end
      if (closing) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_product <= mul;
      p_last    <= head.last;
      r_scaled  <= rounded;
      r_last    <= p_last;
    end
    if (closing) begin
      result.column_number <= col;
      result.product_sum   <= sum32;
      result.final_result  <= col_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cfg_clear |=> (acc == '0) && (col == '0))
    else $error("configuration write did not clear accumulation state");

  assert property (@(posedge clk) disable iff (rst)
    (closing && col_last) |=> (col == '0) && result.valid && result.final_result)
    else $error("final column did not wrap the column counter");

endmodule

[design/matrix_vector_product.sv]
// Matrix-vector product, signed Q16.16: vector items (op 0) load the vector
// store, matrix items (op 1) stream one column at a time and each column's
// dot product comes out saturated to 32 bits, the last column marked final.
// Sustained rate is one item per clock while item.ready is high. A result is
// presented once its last item passes the front, queue, product and rounding
// stages, and transfers with result.ready high. The rate is set by the single
// 32x32 multiplier and the one-add-per-cycle saturating accumulator, fed by
// one read port of the vector store. A four-entry job queue parts the front
// (accept, store write, coefficient fetch) from the back (multiply, round,
// accumulate), so a stalled result only stops intake once the queue fills.
// Writing either size register clears the accumulator and column counter;
// write them only while no column is in progress. Sizes of 0 act as 1, and
// sizes above the store depth act as the depth. The vector store has no
// reset; reading an entry that was never written gives an undefined value.
module matrix_vector_product #(
  parameter int MAX_LENGTH    = mvp_pkg::MAX_LENGTH_DEFAULT,
  parameter int FRACTION_BITS = mvp_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  mvp_item_if.sink    item,
  mvp_result_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = (MAX_LENGTH < 64) ? MAX_LENGTH : 64;
  localparam int SB    = mvp_pkg::SIZE_BITS;
  localparam int CW    = $clog2(mvp_pkg::QUEUE_DEPTH + 1);

  logic [SB-1:0]      vector_length;
  logic [SB-1:0]      column_count;
  logic [SB-1:0]      eff_len;
  logic [SB-1:0]      eff_cols;
  logic               cfg_write;
  logic               reg_sel;
  logic               push;
  logic               pop;
  logic               head_valid;
  mvp_pkg::mac_item_t push_data;
  mvp_pkg::mac_item_t head;
  logic [CW-1:0]      q_count;

  // Configuration port: zero-wait writes, register picked by address bit 2
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= SB'(64);
      column_count  <= SB'(64);
    end else if (cfg_write) begin
      case (reg_sel)
        mvp_pkg::REG_VECTOR_LENGTH: vector_length <= pwdata[SB-1:0];
        mvp_pkg::REG_COLUMN_COUNT:  column_count  <= pwdata[SB-1:0];
        default:                    vector_length <= vector_length;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mvp_pkg::REG_VECTOR_LENGTH: prdata = 32'(vector_length);
      mvp_pkg::REG_COLUMN_COUNT:  prdata = 32'(column_count);
      default:                    prdata = '0;
    endcase
  end

  // Clamp the raw sizes into 1..DEPTH
  always_comb begin
    if (vector_length == '0) begin
      eff_len = SB'(1);
    end else if (vector_length > SB'(DEPTH)) begin
      eff_len = SB'(DEPTH);
    end else begin
      eff_len = vector_length;
    end
    if (column_count == '0) begin
      eff_cols = SB'(1);
    end else if (column_count > SB'(DEPTH)) begin
      eff_cols = SB'(DEPTH);
    end else begin
      eff_cols = column_count;
    end
  end

  mvp_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .eff_len   (eff_len),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  mvp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  mvp_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_clear  (cfg_write),
    .eff_cols   (eff_cols),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule
